[design/mgfm_pkg.sv]
// Shared types, constants and GF(2^8) helper functions for the masked share multiplier.
// No dependencies; imported by mgfm_combine and masked_gf256_share_multiplier.
package mgfm_pkg;

    localparam int SHARE_W   = 8;
    localparam int PROD_W    = 2 * SHARE_W - 1;
    localparam int SHARES_W  = 32;
    localparam int RND_W     = 40;
    localparam int RND_BYTES = RND_W / SHARE_W;

    // AES field polynomial x^8+x^4+x^3+x+1
    localparam logic [SHARE_W:0] GF_POLY = 9'h11B;

    typedef logic [SHARE_W-1:0] byte_t;
    typedef logic [PROD_W-1:0]  clprod_t;

    // carry-less 8x8 product, 15 bits
    function automatic clprod_t clmul8(input byte_t x, input byte_t y);
        clprod_t acc;
        acc = '0;
        for (int k = 0; k < SHARE_W; k++)
        begin
            if (y[k])
            begin
                acc = acc ^ (clprod_t'(x) << k);
            end
        end
        return acc;
    endfunction

    // reduce a 15-bit carry-less product modulo the field polynomial
    function automatic byte_t gf_reduce(input clprod_t p);
        clprod_t r;
        r = p;
        for (int k = PROD_W - 1; k >= SHARE_W; k--)
        begin
            if (r[k])
            begin
                r = r ^ (clprod_t'(GF_POLY) << (k - SHARE_W));
            end
        end
        return r[SHARE_W-1:0];
    endfunction

endpackage

[design/mgfm_combine.sv]
// Share recombination: folds reduced cross products with the randomness tables.
// Depends on mgfm_pkg.
module mgfm_combine
    import mgfm_pkg::*;
#(
    parameter int MASK_ORDER = 3
)
(
    input  logic [SHARE_W-1:0]  prod [0:MASK_ORDER][0:MASK_ORDER],
    input  logic [SHARE_W-1:0]  pr   [0:MASK_ORDER][0:MASK_ORDER],
    input  logic [SHARE_W-1:0]  sr   [0:MASK_ORDER],
    output logic [SHARES_W-1:0] shares
);

    // per-share fold; all indices are elaboration constants
    always_comb
    begin
        byte_t c;
        shares = '0;
        for (int i = 0; i <= MASK_ORDER; i++)
        begin
            c = prod[i][i];
            for (int j = MASK_ORDER; j >= i + 2; j -= 2)
            begin
                c = c ^ pr[i][j] ^ prod[i][j] ^ prod[j][i]
                      ^ sr[j-1] ^ prod[i][j-1] ^ prod[j-1][i];
            end
            if ((i % 2) != (MASK_ORDER % 2))
            begin
                c = c ^ pr[i][i+1] ^ prod[i][i+1] ^ prod[i+1][i];
                if ((i % 2) == 1)
                begin
                    c = c ^ sr[i];
                end
            end
            else
            begin
                for (int j = i - 1; j >= 0; j--)
                begin
                    c = c ^ pr[j][i];
                end
            end
            shares[SHARE_W*i +: SHARE_W] = c;
        end
    end

endmodule

[design/masked_gf256_share_multiplier.sv]
// Top level of the masked GF(2^8) share multiplier: four-stage pipeline.
// Depends on mgfm_pkg and mgfm_combine.
//
//  channel   handshake             fields                                  direction
//  request   in_valid/in_ready     a_shares, b_shares, random_bytes        into block
//  result    out_valid/out_ready   product_shares                          out of block
//
// One request per cycle sustained while out_ready stays high; four register
// stages, the first loaded at the accepting edge, out_valid driven by the last.
// Stages: input/randomness spread, carry-less products, field reduction,
// share fold. Reset clears only the stage valid bits. A stall at the output
// backs up stage by stage; a stage loads whenever it is empty or its content
// moves on, so no request is lost or repeated.
module masked_gf256_share_multiplier
    import mgfm_pkg::*;
#(
    parameter int MASK_ORDER = 3
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SHARES_W-1:0] a_shares,
    input  logic [SHARES_W-1:0] b_shares,
    input  logic [RND_W-1:0]    random_bytes,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SHARES_W-1:0] product_shares
);

    localparam int NS = MASK_ORDER + 1;

    // stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic load1, load2, load3, load4;

    assign load4    = !v4_reg || out_ready;
    assign load3    = !v3_reg || load4;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign in_ready = load1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (load1) v1_reg <= in_valid;
            if (load2) v2_reg <= v1_reg;
            if (load3) v3_reg <= v2_reg;
            if (load4) v4_reg <= v3_reg;
        end
    end

    // stage 1: share bytes and randomness spread into pairwise/single tables
    byte_t a1_reg  [NS];
    byte_t b1_reg  [NS];
    byte_t pr1_reg [NS][NS];
    byte_t sr1_reg [NS];
    byte_t pr1_next [NS][NS];
    byte_t sr1_next [NS];

    always_comb
    begin
        int pos;
        pos = 0;
        for (int i = 0; i < NS; i++)
        begin
            sr1_next[i] = '0;
            for (int j = 0; j < NS; j++)
            begin
                pr1_next[i][j] = '0;
            end
        end
        for (int i = 0; i <= MASK_ORDER; i++)
        begin
            for (int j = 0; j <= MASK_ORDER - i - 1; j += 2)
            begin
                if (pos < RND_BYTES)
                begin
                    pr1_next[i][MASK_ORDER-j] = random_bytes[SHARE_W*pos +: SHARE_W];
                end
                pos = pos + 1;
            end
        end
        for (int j = MASK_ORDER - 1; j >= 1; j -= 2)
        begin
            if (pos < RND_BYTES)
            begin
                sr1_next[j] = random_bytes[SHARE_W*pos +: SHARE_W];
            end
            pos = pos + 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            for (int i = 0; i < NS; i++)
            begin
                a1_reg[i]  <= a_shares[SHARE_W*i +: SHARE_W];
                b1_reg[i]  <= b_shares[SHARE_W*i +: SHARE_W];
                sr1_reg[i] <= sr1_next[i];
                for (int j = 0; j < NS; j++)
                begin
                    pr1_reg[i][j] <= pr1_next[i][j];
                end
            end
        end
    end

    // stage 2: carry-less products of every share pair
    clprod_t p2_reg  [NS][NS];
    byte_t   pr2_reg [NS][NS];
    byte_t   sr2_reg [NS];

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            for (int i = 0; i < NS; i++)
            begin
                sr2_reg[i] <= sr1_reg[i];
                for (int j = 0; j < NS; j++)
                begin
                    p2_reg[i][j]  <= clmul8(a1_reg[i], b1_reg[j]);
                    pr2_reg[i][j] <= pr1_reg[i][j];
                end
            end
        end
    end

    // stage 3: reduction modulo the field polynomial
    byte_t q3_reg  [0:MASK_ORDER][0:MASK_ORDER];
    byte_t pr3_reg [0:MASK_ORDER][0:MASK_ORDER];
    byte_t sr3_reg [0:MASK_ORDER];

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            for (int i = 0; i < NS; i++)
            begin
                sr3_reg[i] <= sr2_reg[i];
                for (int j = 0; j < NS; j++)
                begin
                    q3_reg[i][j]  <= gf_reduce(p2_reg[i][j]);
                    pr3_reg[i][j] <= pr2_reg[i][j];
                end
            end
        end
    end

    // stage 4: fold into output shares
    logic [SHARES_W-1:0] shares_next;
    logic [SHARES_W-1:0] shares_reg;

    mgfm_combine #(
        .MASK_ORDER (MASK_ORDER)
    ) u_combine (
        .prod   (q3_reg),
        .pr     (pr3_reg),
        .sr     (sr3_reg),
        .shares (shares_next)
    );

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            shares_reg <= shares_next;
        end
    end

    assign out_valid      = v4_reg;
    assign product_shares = shares_reg;

endmodule
